### rtl/lvs_pkg.sv
package lvs_pkg;

    // shared datapath widths of the serial units
    localparam int MUL_A_W = 64;
    localparam int MUL_B_W = 32;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;
    localparam int DIV_N_W = 96;
    localparam int DIV_D_W = 48;

    // saturation limits
    localparam logic [30:0] MAX31 = '1;
    localparam logic [46:0] MAX47 = '1;
    localparam logic [47:0] MAX48 = '1;

    localparam logic signed [15:0] PCT_FULL = 16'sd25600;
    localparam logic [12:0] RPM_IDLE = 13'd800;
    localparam logic [12:0] RPM_MAX  = 13'd7000;

    localparam logic [DIV_D_W-1:0] KW_DIVISOR   = 48'd1000;
    localparam logic [DIV_D_W-1:0] IDLE_DIVISOR = 48'd4500;
    localparam logic [DIV_D_W-1:0] FUEL_DIVISOR = 48'd10800;
    localparam logic [MUL_B_W-1:0] RATE_SCALE   = 32'd100000;

    // register reset values (default vehicle)
    localparam logic [31:0] RST_DRIVE_GAIN    = 32'd2293760;
    localparam logic [31:0] RST_BRAKE_GAIN    = 32'd5242880;
    localparam logic [31:0] RST_BRAKE_LIMIT   = 32'd884736000;
    localparam logic [31:0] RST_DRAG_GAIN     = 32'd30106;
    localparam logic [31:0] RST_ROLLING_FORCE = 32'd14465434;
    localparam logic [31:0] RST_INVERSE_MASS  = 32'd2863311;
    localparam logic [31:0] RST_RPM_GAIN      = 32'd7301268;
    localparam logic [31:0] RST_PRESSURE_GAIN = 32'd107374182;

    typedef enum logic [2:0] {
        REG_DRIVE_GAIN,
        REG_BRAKE_GAIN,
        REG_BRAKE_LIMIT,
        REG_DRAG_GAIN,
        REG_ROLLING_FORCE,
        REG_INVERSE_MASS,
        REG_RPM_GAIN,
        REG_PRESSURE_GAIN
    } cfg_index_t;

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_LAUNCH = 4'b0010,
        ST_WAIT   = 4'b0100,
        ST_OUT    = 4'b1000
    } state_t;

    typedef enum logic [3:0] {
        SP_DRIVE,
        SP_BRAKE,
        SP_VSQ,
        SP_DRAG,
        SP_ACC,
        SP_DV,
        SP_POS,
        SP_RPM,
        SP_POW,
        SP_KW,
        SP_KD,
        SP_FUEL,
        SP_PRES,
        SP_NUM,
        SP_RATE
    } step_t;

endpackage

### rtl/lvs_mul.sv
module lvs_mul (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           start,
    input  logic [lvs_pkg::MUL_A_W-1:0]    a,
    input  logic [lvs_pkg::MUL_B_W-1:0]    b,
    output logic                           done,
    output logic [lvs_pkg::PROD_W-1:0]     p
);

    localparam int CNT_W = $clog2(lvs_pkg::MUL_B_W);

    logic [lvs_pkg::MUL_A_W-1:0] a_reg;
    logic [lvs_pkg::MUL_B_W-1:0] b_reg;
    logic [lvs_pkg::PROD_W-1:0]  acc_reg;
    logic [CNT_W-1:0]            cnt_reg;
    logic                        busy_reg;
    logic                        done_reg;
    logic [lvs_pkg::MUL_A_W:0]   sum;

    // one multiplier bit per cycle, lsb first, partial sum shifts right
    assign sum = {1'b0, acc_reg[lvs_pkg::PROD_W-1:lvs_pkg::MUL_B_W]}
               + (b_reg[0] ? {1'b0, a_reg} : '0);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
            end else if (busy_reg && cnt_reg == CNT_W'(lvs_pkg::MUL_B_W - 1)) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            a_reg   <= a;
            b_reg   <= b;
            acc_reg <= '0;
            cnt_reg <= '0;
        end else if (busy_reg) begin
            acc_reg <= {sum, acc_reg[lvs_pkg::MUL_B_W-1:1]};
            b_reg   <= b_reg >> 1;
            cnt_reg <= cnt_reg + 1'b1;
        end
    end

    assign done = done_reg;
    assign p    = acc_reg;

endmodule

### rtl/lvs_div.sv
module lvs_div (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           start,
    input  logic [lvs_pkg::DIV_N_W-1:0]    num,
    input  logic [lvs_pkg::DIV_D_W-1:0]    den,
    output logic                           done,
    output logic [lvs_pkg::DIV_N_W-1:0]    q
);

    localparam int CNT_W = $clog2(lvs_pkg::DIV_N_W);

    logic [lvs_pkg::DIV_N_W-1:0] quo_reg;
    logic [lvs_pkg::DIV_D_W-1:0] rem_reg;
    logic [lvs_pkg::DIV_D_W-1:0] den_reg;
    logic [CNT_W-1:0]            cnt_reg;
    logic                        busy_reg;
    logic                        done_reg;
    logic [lvs_pkg::DIV_D_W:0]   shifted;
    logic [lvs_pkg::DIV_D_W:0]   diff;
    logic                        fits;

    // restoring division, one quotient bit per cycle, msb first
    assign shifted = {rem_reg, quo_reg[lvs_pkg::DIV_N_W-1]};
    assign diff    = shifted - {1'b0, den_reg};
    assign fits    = shifted >= {1'b0, den_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
            end else if (busy_reg && cnt_reg == CNT_W'(lvs_pkg::DIV_N_W - 1)) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            quo_reg <= num;
            rem_reg <= '0;
            den_reg <= den;
            cnt_reg <= '0;
        end else if (busy_reg) begin
            rem_reg <= fits ? diff[lvs_pkg::DIV_D_W-1:0] : shifted[lvs_pkg::DIV_D_W-1:0];
            quo_reg <= {quo_reg[lvs_pkg::DIV_N_W-2:0], fits};
            cnt_reg <= cnt_reg + 1'b1;
        end
    end

    assign done = done_reg;
    assign q    = quo_reg;

endmodule

### rtl/longitudinal_vehicle_step.sv
// Longitudinal vehicle plant: one explicit Euler step per input beat.
// s_ channel: one beat carries throttle, brake, target speed and time step.
// m_ channel: one result beat per input beat with speed, distance, power,
// brake pressure, fuel per 100 km, speed error and engine rpm.
// cfg port: a write at any clock with cfg_wr_en high loads one vehicle gain;
// write only while the block is idle.
// The step runs as a fixed sequence of 12 products on a bit-serial
// shift-add multiplier and 3 quotients on a bit-serial restoring divider,
// so a new beat is not taken while a step is still running. One step is
// in flight at a time; the next beat is taken as soon as the result is in
// the output register.
// Reset clears velocity, position and fuel, sets rpm to idle and loads the
// default vehicle gains. When the receiver stalls, the result is held in the
// output register; a further step completes its sequence and then waits
// until the held beat is taken.
module longitudinal_vehicle_step #(
    parameter int FRAC_BITS = 16
) (
    input  logic         aclk,
    input  logic         aresetn,
    // throttle_cmd, brake_cmd, speed_goal, time_step, pad
    input  logic [79:0]  s_tdata,
    input  logic         s_tvalid,
    output logic         s_tready,
    // speed_out, distance_travelled, power_kw, brake_bar,
    // fuel_per_100km, speed_error, rpm_out
    output logic [215:0] m_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    input  logic         cfg_wr_en,
    input  logic [2:0]   cfg_index,
    input  logic [31:0]  cfg_data
);

    localparam int NSH_L = (2 * FRAC_BITS >= 32) ? 2 * FRAC_BITS - 32 : 0;
    localparam int NSH_R = (2 * FRAC_BITS >= 32) ? 0 : 32 - 2 * FRAC_BITS;
    localparam int PW    = lvs_pkg::PROD_W;

    // vehicle gains
    logic [31:0] drive_gain_reg, brake_gain_reg, brake_limit_reg, drag_gain_reg;
    logic [31:0] rolling_force_reg, inverse_mass_reg, rpm_gain_reg, pressure_gain_reg;

    // control
    lvs_pkg::state_t state_reg;
    lvs_pkg::step_t  step_reg;
    logic            m_tvalid_reg;
    logic [215:0]    m_tdata_reg;

    // captured input beat
    logic [14:0] thr_reg, brk_reg;
    logic [30:0] target_reg;
    logic [15:0] dt_reg;

    // plant state
    logic [30:0] velocity_reg;
    logic [46:0] position_reg;
    logic [47:0] fuel_reg;
    logic [12:0] rpm_reg;

    // step intermediates
    logic [38:0] f_drive_reg;
    logic [31:0] f_brake_reg;
    logic [63:0] v2_reg;
    logic [49:0] resist_reg;
    logic [47:0] acc_reg;
    logic [63:0] pw_reg;
    logic [30:0] kw_reg;
    logic [46:0] kd_reg;
    logic [30:0] pres_reg;
    logic [95:0] n_reg;
    logic [30:0] rate_reg;

    // serial units
    logic                          mul_start, div_start, mul_done, div_done;
    logic [lvs_pkg::MUL_A_W-1:0]   mul_a;
    logic [lvs_pkg::MUL_B_W-1:0]   mul_b;
    logic [PW-1:0]                 mul_p;
    logic [lvs_pkg::DIV_N_W-1:0]   div_num, div_q;
    logic [lvs_pkg::DIV_D_W-1:0]   div_den;
    logic                          step_is_div;

    // combinational helpers
    logic signed [15:0] thr_in, brk_in;
    logic [14:0]        thr_clamp, brk_clamp;
    logic               accel, drag_on, idle_fuel, dist_ok;
    logic [49:0]        mag;
    logic [PW-1:0]      p_sh_f, p_sh_2f;
    logic [38:0]        brake_raw;
    logic [47:0]        drag48, roll48;
    logic [30:0]        dv;
    logic [31:0]        v_sum;
    logic [30:0]        vn;
    logic [47:0]        pos_sum;
    logic [48:0]        fuel_sum;
    logic [95:0]        fuel_num;
    logic               s_fire, out_free;

    assign s_fire   = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;
    assign s_tready = state_reg == lvs_pkg::ST_IDLE;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // command clamp to 0..100 percent
    always_comb begin
        thr_in = s_tdata[15:0];
        brk_in = s_tdata[31:16];
        if (thr_in < 16'sd0) begin
            thr_clamp = '0;
        end else if (thr_in > lvs_pkg::PCT_FULL) begin
            thr_clamp = lvs_pkg::PCT_FULL[14:0];
        end else begin
            thr_clamp = thr_in[14:0];
        end
        if (brk_in < 16'sd0) begin
            brk_clamp = '0;
        end else if (brk_in > lvs_pkg::PCT_FULL) begin
            brk_clamp = lvs_pkg::PCT_FULL[14:0];
        end else begin
            brk_clamp = brk_in[14:0];
        end
    end

    // flags and per-step datapath
    assign drag_on   = ({4'b0, velocity_reg} * 35'd10) >= (35'd1 << FRAC_BITS);
    assign idle_fuel = ({4'b0, kw_reg} * 35'd10) < (35'd1 << FRAC_BITS);
    assign dist_ok   = ({10'b0, position_reg} * 57'd1000) > (57'd1 << FRAC_BITS);
    assign accel     = {11'b0, f_drive_reg} >= resist_reg;
    assign mag       = accel ? {11'b0, f_drive_reg} - resist_reg
                             : resist_reg - {11'b0, f_drive_reg};
    assign p_sh_f    = mul_p >> FRAC_BITS;
    assign p_sh_2f   = mul_p >> (2 * FRAC_BITS);
    assign brake_raw = mul_p[46:8];
    assign drag48    = (|p_sh_f[PW-1:48]) ? lvs_pkg::MAX48 : p_sh_f[47:0];
    assign roll48    = (velocity_reg != '0) ? {16'b0, rolling_force_reg} : '0;
    assign dv        = (|mul_p[PW-1:47]) ? lvs_pkg::MAX31 : mul_p[46:16];
    assign v_sum     = {1'b0, velocity_reg} + {1'b0, dv};
    assign pos_sum   = {1'b0, position_reg} + {17'b0, mul_p[46:16]};
    assign fuel_sum  = {1'b0, fuel_reg} + {1'b0, div_q[47:0]};
    assign fuel_num  = idle_fuel ? {64'b0, dt_reg, 16'b0}
                                 : (({49'b0, kd_reg} << 16) >> FRAC_BITS);

    always_comb begin
        if (accel) begin
            vn = v_sum[31] ? lvs_pkg::MAX31 : v_sum[30:0];
        end else begin
            vn = (dv >= velocity_reg) ? '0 : velocity_reg - dv;
        end
    end

    // operand selection for the current step
    always_comb begin
        mul_a       = '0;
        mul_b       = '0;
        div_num     = '0;
        div_den     = '0;
        step_is_div = 1'b0;
        case (step_reg)
            lvs_pkg::SP_DRIVE: begin
                mul_a = {32'b0, drive_gain_reg};
                mul_b = {17'b0, thr_reg};
            end
            lvs_pkg::SP_BRAKE: begin
                mul_a = {32'b0, brake_gain_reg};
                mul_b = {17'b0, brk_reg};
            end
            lvs_pkg::SP_VSQ: begin
                mul_a = {33'b0, velocity_reg};
                mul_b = {1'b0, velocity_reg};
            end
            lvs_pkg::SP_DRAG: begin
                mul_a = v2_reg;
                mul_b = drag_gain_reg;
            end
            lvs_pkg::SP_ACC: begin
                mul_a = {14'b0, mag};
                mul_b = inverse_mass_reg;
            end
            lvs_pkg::SP_DV: begin
                mul_a = {16'b0, acc_reg};
                mul_b = {16'b0, dt_reg};
            end
            lvs_pkg::SP_POS: begin
                mul_a = {33'b0, velocity_reg};
                mul_b = {16'b0, dt_reg};
            end
            lvs_pkg::SP_RPM: begin
                mul_a = {33'b0, velocity_reg};
                mul_b = rpm_gain_reg;
            end
            lvs_pkg::SP_POW: begin
                mul_a = {25'b0, f_drive_reg};
                mul_b = {1'b0, velocity_reg};
            end
            lvs_pkg::SP_KW: begin
                step_is_div = 1'b1;
                div_num     = {32'b0, pw_reg};
                div_den     = lvs_pkg::KW_DIVISOR;
            end
            lvs_pkg::SP_KD: begin
                mul_a = {33'b0, kw_reg};
                mul_b = {16'b0, dt_reg};
            end
            lvs_pkg::SP_FUEL: begin
                step_is_div = 1'b1;
                div_num     = fuel_num;
                div_den     = idle_fuel ? lvs_pkg::IDLE_DIVISOR : lvs_pkg::FUEL_DIVISOR;
            end
            lvs_pkg::SP_PRES: begin
                mul_a = {32'b0, f_brake_reg};
                mul_b = pressure_gain_reg;
            end
            lvs_pkg::SP_NUM: begin
                mul_a = {16'b0, fuel_reg};
                mul_b = lvs_pkg::RATE_SCALE;
            end
            lvs_pkg::SP_RATE: begin
                step_is_div = 1'b1;
                div_num     = n_reg;
                div_den     = {1'b0, position_reg};
            end
            default: begin
                step_is_div = 1'b0;
            end
        endcase
    end

    assign mul_start = (state_reg == lvs_pkg::ST_LAUNCH) && !step_is_div;
    assign div_start = (state_reg == lvs_pkg::ST_LAUNCH) && step_is_div;

    lvs_mul u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mul_start),
        .a       (mul_a),
        .b       (mul_b),
        .done    (mul_done),
        .p       (mul_p)
    );

    lvs_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (div_num),
        .den     (div_den),
        .done    (div_done),
        .q       (div_q)
    );

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            drive_gain_reg    <= lvs_pkg::RST_DRIVE_GAIN;
            brake_gain_reg    <= lvs_pkg::RST_BRAKE_GAIN;
            brake_limit_reg   <= lvs_pkg::RST_BRAKE_LIMIT;
            drag_gain_reg     <= lvs_pkg::RST_DRAG_GAIN;
            rolling_force_reg <= lvs_pkg::RST_ROLLING_FORCE;
            inverse_mass_reg  <= lvs_pkg::RST_INVERSE_MASS;
            rpm_gain_reg      <= lvs_pkg::RST_RPM_GAIN;
            pressure_gain_reg <= lvs_pkg::RST_PRESSURE_GAIN;
        end else if (cfg_wr_en) begin
            case (lvs_pkg::cfg_index_t'(cfg_index))
                lvs_pkg::REG_DRIVE_GAIN:    drive_gain_reg    <= cfg_data;
                lvs_pkg::REG_BRAKE_GAIN:    brake_gain_reg    <= cfg_data;
                lvs_pkg::REG_BRAKE_LIMIT:   brake_limit_reg   <= cfg_data;
                lvs_pkg::REG_DRAG_GAIN:     drag_gain_reg     <= cfg_data;
                lvs_pkg::REG_ROLLING_FORCE: rolling_force_reg <= cfg_data;
                lvs_pkg::REG_INVERSE_MASS:  inverse_mass_reg  <= cfg_data;
                lvs_pkg::REG_RPM_GAIN:      rpm_gain_reg      <= cfg_data;
                lvs_pkg::REG_PRESSURE_GAIN: pressure_gain_reg <= cfg_data;
                default: begin
                end
            endcase
        end
    end

    // sequencer and plant state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= lvs_pkg::ST_IDLE;
            step_reg     <= lvs_pkg::SP_DRIVE;
            m_tvalid_reg <= 1'b0;
            velocity_reg <= '0;
            position_reg <= '0;
            fuel_reg     <= '0;
            rpm_reg      <= lvs_pkg::RPM_IDLE;
        end else begin
            // a new beat loads while the held one leaves, otherwise valid drops on take
            if (state_reg == lvs_pkg::ST_OUT && out_free) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            case (state_reg)
                lvs_pkg::ST_IDLE: begin
                    if (s_fire) begin
                        thr_reg    <= thr_clamp;
                        brk_reg    <= brk_clamp;
                        target_reg <= s_tdata[62:32];
                        dt_reg     <= s_tdata[78:63];
                        step_reg   <= lvs_pkg::SP_DRIVE;
                        state_reg  <= lvs_pkg::ST_LAUNCH;
                    end
                end
                lvs_pkg::ST_LAUNCH: begin
                    state_reg <= lvs_pkg::ST_WAIT;
                end
                lvs_pkg::ST_WAIT: begin
                    if (mul_done || div_done) begin
                        if (step_reg == lvs_pkg::SP_RATE) begin
                            state_reg <= lvs_pkg::ST_OUT;
                            step_reg  <= lvs_pkg::SP_DRIVE;
                        end else begin
                            state_reg <= lvs_pkg::ST_LAUNCH;
                            step_reg  <= lvs_pkg::step_t'(step_reg + 4'd1);
                        end
                        case (step_reg)
                            lvs_pkg::SP_DRIVE: f_drive_reg <= mul_p[46:8];
                            lvs_pkg::SP_BRAKE: begin
                                // anti-lock cap
                                f_brake_reg <= (brake_raw > {7'b0, brake_limit_reg})
                                             ? brake_limit_reg : brake_raw[31:0];
                            end
                            lvs_pkg::SP_VSQ: v2_reg <= p_sh_f[63:0];
                            lvs_pkg::SP_DRAG: begin
                                // no drag below 0.1 m/s, rolling only while moving
                                resist_reg <= {2'b0, drag_on ? drag48 : 48'd0}
                                            + {2'b0, roll48} + {18'b0, f_brake_reg};
                            end
                            lvs_pkg::SP_ACC: begin
                                acc_reg <= (|mul_p[PW-1:80]) ? lvs_pkg::MAX48
                                                             : mul_p[79:32];
                            end
                            lvs_pkg::SP_DV: velocity_reg <= vn;
                            lvs_pkg::SP_POS: begin
                                position_reg <= pos_sum[47] ? lvs_pkg::MAX47
                                                            : pos_sum[46:0];
                            end
                            lvs_pkg::SP_RPM: begin
                                if (p_sh_2f > {83'b0, lvs_pkg::RPM_MAX}) begin
                                    rpm_reg <= lvs_pkg::RPM_MAX;
                                end else if (p_sh_2f < {83'b0, lvs_pkg::RPM_IDLE}) begin
                                    rpm_reg <= lvs_pkg::RPM_IDLE;
                                end else begin
                                    rpm_reg <= p_sh_2f[12:0];
                                end
                            end
                            lvs_pkg::SP_POW: pw_reg <= p_sh_f[63:0];
                            lvs_pkg::SP_KW: begin
                                kw_reg <= (|div_q[95:31]) ? lvs_pkg::MAX31 : div_q[30:0];
                            end
                            lvs_pkg::SP_KD: kd_reg <= mul_p[46:0];
                            lvs_pkg::SP_FUEL: begin
                                if (|div_q[95:48] || fuel_sum[48]) begin
                                    fuel_reg <= lvs_pkg::MAX48;
                                end else begin
                                    fuel_reg <= fuel_sum[47:0];
                                end
                            end
                            lvs_pkg::SP_PRES: begin
                                pres_reg <= (|mul_p[PW-1:63]) ? lvs_pkg::MAX31
                                                              : mul_p[62:32];
                            end
                            lvs_pkg::SP_NUM: n_reg <= (mul_p << NSH_L) >> NSH_R;
                            lvs_pkg::SP_RATE: begin
                                // fuel rate stays zero until 0.001 m travelled
                                if (!dist_ok) begin
                                    rate_reg <= '0;
                                end else begin
                                    rate_reg <= (|div_q[95:31]) ? lvs_pkg::MAX31
                                                                : div_q[30:0];
                                end
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                lvs_pkg::ST_OUT: begin
                    // hold until the output register is free
                    if (out_free) begin
                        state_reg <= lvs_pkg::ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= lvs_pkg::ST_IDLE;
                end
            endcase
        end
    end

    // result beat
    always_ff @(posedge aclk) begin
        if (state_reg == lvs_pkg::ST_OUT && out_free) begin
            m_tdata_reg <= {rpm_reg,
                            {1'b0, target_reg} - {1'b0, velocity_reg},
                            rate_reg,
                            pres_reg,
                            kw_reg,
                            position_reg,
                            velocity_reg};
        end
    end

    // the two serial units never finish in the same cycle
    a_units_exclusive: assert property (@(posedge aclk) disable iff (!aresetn)
        mul_done |-> !div_done)
        else $error("multiplier and divider finished together");

    // an accepted beat starts the sequence at its first step
    a_seq_start: assert property (@(posedge aclk) disable iff (!aresetn)
        s_fire |=> (state_reg == lvs_pkg::ST_LAUNCH && step_reg == lvs_pkg::SP_DRIVE))
        else $error("step sequence did not start on accepted beat");

    // reported rpm stays between idle and redline
    a_rpm_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[215:203] >= lvs_pkg::RPM_IDLE
                      && m_tdata[215:203] <= lvs_pkg::RPM_MAX))
        else $error("engine rpm out of range");

endmodule
